### hdl/cdgm_pkg.sv
`default_nettype none
package cdgm_pkg;
  localparam int RING_DEPTH  = 8192;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int SAMPLE_BITS = 16;
  localparam int PLANE_W     = 48;
  localparam int SUM_W       = 2 * SAMPLE_BITS + 2;
  localparam int MAG_W       = 17;
  localparam int ROOT_STEPS  = SUM_W / 2;

  localparam logic [2:0] REG_SIZE_X = 3'd0;
  localparam logic [2:0] REG_SIZE_Y = 3'd1;
  localparam logic [2:0] REG_SIZE_Z = 3'd2;
  localparam logic [2:0] REG_SIZE_T = 3'd3;
  localparam logic [2:0] REG_SIZE_C = 3'd4;
  localparam logic [2:0] REG_AXIS   = 3'd5;

  typedef struct packed {
    logic                   fill;
    logic [RING_AW-1:0]     wp;
    logic [RING_AW-1:0]     ca;
    logic [SAMPLE_BITS-1:0] val;
    logic                   border;
    logic                   last;
  } job_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             on_border;
    logic             last;
  } res_t;
endpackage
`default_nettype wire

### hdl/cdgm_front.sv
`default_nettype none
module cdgm_front
  import cdgm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   restart,
  input  wire logic [15:0]            ex,
  input  wire logic [11:0]            ey,
  input  wire logic [11:0]            ez,
  input  wire logic [11:0]            et,
  input  wire logic [11:0]            ec,
  input  wire logic [1:0]             mode,
  input  wire logic [PLANE_W-1:0]     plane,
  input  wire logic                   push,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   flush,
  output logic                        full,
  output logic                        job_valid,
  output job_t                        job,
  input  wire logic                   job_ready
);
  logic [PLANE_W:0]   plane2;
  logic [RING_AW:0]   wp_r, wp_nxt, wp_inc;
  logic [RING_AW:0]   seen_r, seen_nxt;
  logic [11:0]        cc_r, ct_r, cz_r, cy_r;
  logic [15:0]        cx_r;
  logic               hv_r;
  job_t               hold_r;
  logic               take, ok, fill, brd, lst;
  logic [RING_AW:0]   ca;

  assign plane2 = {plane, 1'b0};
  assign ok   = plane2 <= (PLANE_W+1)'(RING_DEPTH);
  assign full = hv_r & ~job_ready;
  assign take = push & ~full & ok;
  assign fill = {{(PLANE_W-RING_AW-1){1'b0}}, seen_r} < plane;
  assign wp_inc = wp_r + 1'b1;
  assign wp_nxt = ({{(PLANE_W-RING_AW){1'b0}}, wp_inc} >= plane2) ? '0 : wp_inc;
  assign ca = ({{(PLANE_W-RING_AW-1){1'b0}}, wp_r} >= plane) ?
              wp_r - plane[RING_AW:0] : wp_r + plane[RING_AW:0];
  assign seen_nxt = seen_r + 1'b1;
  assign brd = cx_r == 16'd0 || cx_r == ex - 16'd1 || cy_r == 12'd0 || cy_r == ey - 12'd1 ||
               (mode[0] && (cz_r == 12'd0 || cz_r == ez - 12'd1)) ||
               (mode[1] && (ct_r == 12'd0 || ct_r == et - 12'd1));
  assign lst = cc_r == ec - 12'd1 && ct_r == et - 12'd1 && cz_r == ez - 12'd1 &&
               cy_r == ey - 12'd1 && cx_r == ex - 16'd1;
  assign job_valid = hv_r;
  assign job = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
    end else if (take) begin
      hv_r <= 1'b1;
    end else if (job_ready) begin
      hv_r <= 1'b0;
    end
    if (take) begin
      hold_r.fill   <= fill;
      hold_r.wp     <= wp_r[RING_AW-1:0];
      hold_r.ca     <= ca[RING_AW-1:0];
      hold_r.val    <= flush ? '0 : sample;
      hold_r.border <= brd;
      hold_r.last   <= lst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      wp_r <= '0; seen_r <= '0;
      cc_r <= '0; ct_r <= '0; cz_r <= '0; cy_r <= '0; cx_r <= '0;
    end else if (take) begin
      if (fill) begin
        wp_r <= wp_nxt;
        seen_r <= seen_nxt;
      end else if (lst) begin
        wp_r <= '0; seen_r <= '0;
        cc_r <= '0; ct_r <= '0; cz_r <= '0; cy_r <= '0; cx_r <= '0;
      end else begin
        wp_r <= wp_nxt;
        if (cc_r + 12'd1 >= ec) begin
          cc_r <= '0;
          if (ct_r + 12'd1 >= et) begin
            ct_r <= '0;
            if (cz_r + 12'd1 >= ez) begin
              cz_r <= '0;
              if (cy_r + 12'd1 >= ey) begin
                cy_r <= '0;
                cx_r <= cx_r + 16'd1;
              end else begin
                cy_r <= cy_r + 12'd1;
              end
            end else begin
              cz_r <= cz_r + 12'd1;
            end
          end else begin
            ct_r <= ct_r + 12'd1;
          end
        end else begin
          cc_r <= cc_r + 12'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hdl/cdgm_back.sv
`default_nettype none
module cdgm_back
  import cdgm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [1:0]         mode,
  input  wire logic [PLANE_W-1:0] st_y,
  input  wire logic [PLANE_W-1:0] st_z,
  input  wire logic [PLANE_W-1:0] st_t,
  input  wire logic               job_valid,
  input  job_t                    job,
  output logic                    job_ready,
  output logic                    out_valid,
  output res_t                    res,
  input  wire logic               res_pop
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic [2:0]             st_r;
  job_t                   j_r;
  logic [1:0]             rc_r;
  logic [SAMPLE_BITS-1:0] qa_r, qb_r;
  logic [SUM_W-1:0]       sum_r, rem_r, root_r;
  logic [$clog2(ROOT_STEPS+1)-1:0] it_r;
  logic [SAMPLE_BITS:0]   d;
  logic [SAMPLE_BITS:0]   ad;
  logic [2*SAMPLE_BITS+1:0] sq;
  logic [RING_AW+PLANE_W:0] aa, ab;
  logic [PLANE_W-1:0]     stp;
  logic [SUM_W-1:0]       bit_v, trial;
  logic                   ina, inb, xa;
  logic                   ov_r;
  res_t                   res_r;
  logic                   emit;

  assign job_ready = st_r == S_IDLE;
  assign out_valid = ov_r;
  assign res = res_r;
  assign emit = st_r == S_OUT && (!ov_r || res_pop);

  always_comb begin
    case (rc_r)
      2'd1:    stp = st_y;
      2'd2:    stp = st_z;
      default: stp = st_t;
    endcase
    aa = {{(PLANE_W+1){1'b0}}, j_r.ca} - {{(RING_AW+1){1'b0}}, stp};
    ab = {{(PLANE_W+1){1'b0}}, j_r.ca} + {{(RING_AW+1){1'b0}}, stp};
    xa = rc_r == 2'd0;
    if (xa) begin
      aa = {{(PLANE_W+1){1'b0}}, j_r.wp};
    end
    ina = aa < (RING_AW+PLANE_W+1)'(RING_DEPTH);
    inb = ab < (RING_AW+PLANE_W+1)'(RING_DEPTH);
    d  = {1'b0, qa_r} - {1'b0, qb_r};
    ad = d[SAMPLE_BITS] ? -d : d;
    sq = (2*SAMPLE_BITS+2)'(ad) * (2*SAMPLE_BITS+2)'(ad);
    bit_v = SUM_W'(1) << (2 * (ROOT_STEPS - 1 - it_r));
    trial = root_r + bit_v;
  end

  always_ff @(posedge clk) begin
    if (st_r == S_RD) begin
      qa_r <= ina ? ring[aa[RING_AW-1:0]] : '0;
      qb_r <= xa ? j_r.val : (inb ? ring[ab[RING_AW-1:0]] : '0);
    end
    if (job_valid && job_ready && job.fill) begin
      ring[job.wp] <= job.val;
    end else if (emit) begin
      ring[j_r.wp] <= j_r.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (emit) begin
        ov_r <= 1'b1;
      end else if (res_pop) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (job_valid) begin
            j_r <= job;
            rc_r <= '0;
            sum_r <= '0;
            if (job.fill) st_r <= S_IDLE;
            else if (job.border) st_r <= S_OUT;
            else st_r <= S_RD;
          end
        end
        S_RD: st_r <= S_SQ;
        S_SQ: begin
          sum_r <= sum_r + SUM_W'(sq);
          if ((rc_r == 2'd1 && mode == 2'd0) || (rc_r == 2'd2 && !mode[1]) ||
              rc_r == 2'd3) begin
            st_r <= S_ROOT;
            it_r <= '0;
            root_r <= '0;
            rem_r <= sum_r + SUM_W'(sq);
          end else begin
            rc_r <= (rc_r == 2'd1 && !mode[0]) ? 2'd3 : rc_r + 2'd1;
            st_r <= S_RD;
          end
        end
        S_ROOT: begin
          if (rem_r >= trial) begin
            rem_r <= rem_r - trial;
            root_r <= (root_r >> 1) + bit_v;
          end else begin
            root_r <= root_r >> 1;
          end
          if (it_r == ($clog2(ROOT_STEPS+1))'(ROOT_STEPS - 1)) st_r <= S_OUT;
          it_r <= it_r + 1'b1;
        end
        S_OUT: begin
          if (emit) begin
            res_r.magnitude <= j_r.border ? '0 : root_r[MAG_W-1:0];
            res_r.on_border <= j_r.border;
            res_r.last <= j_r.last;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/central_difference_gradient_magnitude_unit.sv
`default_nettype none
// channel | ports                                   | beat when
// in      | in_sample, in_flush, push, full          | push & !full
// out     | out_magnitude, out_on_border, out_last   | pop & !empty
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid & cfg_ready
// A filling item only writes the ring; a border voxel goes straight to output; an inner
// voxel reads the ring and squares once per axis difference, then takes 17 root steps.
// Reset clears counters and sizes to 1; the ring holds stale data until written.
// Input holds full after reset and after each write to a defined register (index 0 to 5).
// The front holds one item, the back one result; the front stalls while the back is busy.
module central_difference_gradient_magnitude_unit
  import cdgm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                   in_flush,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [MAG_W-1:0]            out_magnitude,
  output logic                        out_on_border,
  output logic                        out_last,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [15:0]            cfg_data
);
  logic [15:0] sx_r;
  logic [11:0] sy_r, sz_r, stt_r, sc_r;
  logic [1:0]  am_r;
  logic [15:0] ex;
  logic [11:0] ey, ez, et, ec;
  logic [PLANE_W-1:0] sty_r, stz_r, stt2_r, plane_r;
  logic        wr, jv, jr, ov;
  logic [1:0]  settle_r;
  logic        fe_full, fe_push;
  job_t        job;
  res_t        res;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid && cfg_index <= REG_AXIS;
  assign ex = sx_r == '0 ? 16'd1 : sx_r;
  assign ey = sy_r == '0 ? 12'd1 : sy_r;
  assign ez = sz_r == '0 ? 12'd1 : sz_r;
  assign et = stt_r == '0 ? 12'd1 : stt_r;
  assign ec = sc_r == '0 ? 12'd1 : sc_r;
  assign fe_push = push & (settle_r == 2'd0);
  assign full = fe_full | (settle_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= 16'd1; sy_r <= 12'd1; sz_r <= 12'd1; stt_r <= 12'd1; sc_r <= 12'd1;
      am_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SIZE_X: sx_r  <= cfg_data;
        REG_SIZE_Y: sy_r  <= cfg_data[11:0];
        REG_SIZE_Z: sz_r  <= cfg_data[11:0];
        REG_SIZE_T: stt_r <= cfg_data[11:0];
        REG_SIZE_C: sc_r  <= cfg_data[11:0];
        REG_AXIS:   am_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
    stt2_r  <= PLANE_W'(ec);
    stz_r   <= PLANE_W'(et) * PLANE_W'(ec);
    sty_r   <= PLANE_W'(ez) * stz_r;
    plane_r <= PLANE_W'(ey) * sty_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || wr) begin
      settle_r <= 2'd3;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  cdgm_front u_front (
    .clk, .rst_n, .restart(wr), .ex, .ey, .ez, .et, .ec, .mode(am_r),
    .plane(plane_r), .push(fe_push), .sample(in_sample), .flush(in_flush),
    .full(fe_full), .job_valid(jv), .job, .job_ready(jr)
  );

  cdgm_back u_back (
    .clk, .rst_n, .mode(am_r), .st_y(sty_r), .st_z(stz_r), .st_t(stt2_r),
    .job_valid(jv), .job, .job_ready(jr), .out_valid(ov), .res, .res_pop(pop)
  );

  assign empty = ~ov;
  assign out_magnitude = res.magnitude;
  assign out_on_border = res.on_border;
  assign out_last = res.last;
endmodule
`default_nettype wire

### test/central_difference_gradient_magnitude_unit_test.sv
`default_nettype none
module central_difference_gradient_magnitude_unit_test;
  import cdgm_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [15:0] sample;
    logic        flush;
    bit          typed;
    bit          produces;
    res_t        res;
  } stim_row_t;

  logic clk, rst_n, push, in_flush, pop, cfg_valid;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  wire logic full, empty, cfg_ready, out_on_border, out_last;
  wire logic [MAG_W-1:0] out_magnitude;

  central_difference_gradient_magnitude_unit DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_sample(in_sample), .in_flush(in_flush), .empty(empty), .pop(pop),
    .out_magnitude(out_magnitude), .out_on_border(out_on_border), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  res_t grad_expected[$];
  int mismatches = 0;
  int cycles = 0;
  int random_items = 0;
  bit quiet = 0;
  int pop_idle = 0;
  int pop_hold = 0;
  bit hold_done = 0;

  logic [15:0] plane_mem [RING_DEPTH];
  int unsigned sz_x, sz_y, sz_z, sz_t, sz_c, mode_q;
  longint unsigned wr_ptr, filled, at_ch, at_tm, at_dp, at_rw, at_pl;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (grad_expected.size() == 0) begin
        report_mismatch("unexpected beat", out_magnitude, -1);
      end else begin
        want = grad_expected.pop_front();
        if (out_magnitude !== want.magnitude)
          report_mismatch("magnitude", out_magnitude, want.magnitude);
        if (out_on_border !== want.on_border)
          report_mismatch("on_border", out_on_border, want.on_border);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    logic p;
    p = 1;
    if (!hold_done && random_items >= 300) begin
      hold_done = 1;
      pop_hold = 400;
    end
    if (pop_hold > 0) begin
      pop_hold--;
      p = 0;
    end else if (pop_idle > 0) begin
      pop_idle--;
      p = 0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      pop_idle = $urandom_range(1, 9) - 1;
      p = 0;
    end
    pop <= p;
  end

  function automatic longint unsigned eff(input int unsigned v);
    return v == 0 ? 1 : v;
  endfunction

  function automatic longint ring_at(input longint unsigned idx);
    return idx < RING_DEPTH ? longint'({48'd0, plane_mem[idx]}) : 0;
  endfunction

  function automatic void restart_stream();
    wr_ptr = 0; filled = 0;
    at_ch = 0; at_tm = 0; at_dp = 0; at_rw = 0; at_pl = 0;
  endfunction

  task automatic predict_gradient(input logic [15:0] s, input logic f,
                                  output bit produces, output res_t r);
    longint unsigned ex, ey, ez, et, ec, st_z, st_y, pl, wp, ca, sum, root, b;
    longint dx, dy, d;
    bit uz, ut, bord, lst;
    logic [15:0] v;
    produces = 0;
    r = '0;
    ex = eff(sz_x); ey = eff(sz_y); ez = eff(sz_z); et = eff(sz_t); ec = eff(sz_c);
    st_z = et * ec; st_y = ez * et * ec; pl = ey * st_y;
    wp = wr_ptr;
    uz = mode_q[0]; ut = mode_q[1];
    if (pl * 2 > RING_DEPTH || wp >= pl * 2) return;
    v = f ? 16'd0 : s;
    if (filled < pl) begin
      plane_mem[wp] = v;
      wp++;
      if (wp >= pl * 2) wp = 0;
      wr_ptr = wp;
      filled++;
      return;
    end
    ca = (wp >= pl) ? wp - pl : wp + pl;
    bord = at_pl == 0 || at_pl == ex - 1 || at_rw == 0 || at_rw == ey - 1 ||
           (uz && (at_dp == 0 || at_dp == ez - 1)) ||
           (ut && (at_tm == 0 || at_tm == et - 1));
    root = 0;
    if (!bord) begin
      dx = ring_at(wp) - longint'({48'd0, v});
      dy = ring_at(ca - st_y) - ring_at(ca + st_y);
      sum = dx * dx + dy * dy;
      if (uz) begin
        d = ring_at(ca - st_z) - ring_at(ca + st_z);
        sum += d * d;
      end
      if (ut) begin
        d = ring_at(ca - ec) - ring_at(ca + ec);
        sum += d * d;
      end
      b = 64'd1 << 62;
      while (b > sum) b >>= 2;
      while (b != 0) begin
        if (sum >= root + b) begin
          sum -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
    end
    lst = at_ch == ec - 1 && at_tm == et - 1 && at_dp == ez - 1 &&
          at_rw == ey - 1 && at_pl == ex - 1;
    r.magnitude = root[MAG_W-1:0];
    r.on_border = bord;
    r.last = lst;
    produces = 1;
    plane_mem[wp] = v;
    if (lst) begin
      restart_stream();
      return;
    end
    wp++;
    if (wp >= pl * 2) wp = 0;
    wr_ptr = wp;
    at_ch++;
    if (at_ch >= ec) begin
      at_ch = 0; at_tm++;
      if (at_tm >= et) begin
        at_tm = 0; at_dp++;
        if (at_dp >= ez) begin
          at_dp = 0; at_rw++;
          if (at_rw >= ey) begin
            at_rw = 0; at_pl++;
          end
        end
      end
    end
  endtask

  task automatic drain();
    while (grad_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_SIZE_X: sz_x = data;
      REG_SIZE_Y: sz_y = data & 16'hFFF;
      REG_SIZE_Z: sz_z = data & 16'hFFF;
      REG_SIZE_T: sz_t = data & 16'hFFF;
      REG_SIZE_C: sz_c = data & 16'hFFF;
      REG_AXIS:   mode_q = data & 16'h3;
      default:    return;
    endcase
    restart_stream();
  endtask

  task automatic set_volume(input int unsigned x, y, z, t, c, m);
    write_reg(REG_SIZE_X, 16'(x));
    write_reg(REG_SIZE_Y, 16'(y));
    write_reg(REG_SIZE_Z, 16'(z));
    write_reg(REG_SIZE_T, 16'(t));
    write_reg(REG_SIZE_C, 16'(c));
    write_reg(REG_AXIS, 16'(m));
  endtask

  task automatic send_beat(input logic [15:0] s, input logic f, input bit typed,
                           input res_t typed_res);
    bit produces;
    res_t r;
    push <= 1;
    in_sample <= s;
    in_flush <= f;
    do @(posedge clk); while (full);
    predict_gradient(s, f, produces, r);
    if (produces) grad_expected.push_back(typed ? typed_res : r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  stim_row_t dir_rows [16] = '{
    '{16'hFFFF, 1'b0, 1, 0, '0},
    '{16'h0000, 1'b1, 1, 1, '{magnitude: 0, on_border: 1, last: 1}},
    '{16'h0000, 1'b0, 1, 0, '0},
    '{16'hFFFF, 1'b1, 1, 1, '{magnitude: 0, on_border: 1, last: 1}},
    '{16'h0000, 1'b0, 0, 0, '0},
    '{16'hFFFF, 1'b0, 0, 0, '0},
    '{16'h0000, 1'b0, 0, 0, '0},
    '{16'hFFFF, 1'b0, 0, 0, '0},
    '{16'h0000, 1'b0, 0, 0, '0},
    '{16'h0000, 1'b0, 0, 0, '0},
    '{16'h0000, 1'b0, 0, 0, '0},
    '{16'h0000, 1'b0, 0, 0, '0},
    '{16'hFFFF, 1'b0, 0, 0, '0},
    '{16'h5A5A, 1'b1, 0, 0, '0},
    '{16'hA5A5, 1'b1, 0, 0, '0},
    '{16'h0000, 1'b1, 0, 0, '0}
  };

  initial begin
    int unsigned x, y, z, t, c, m, plane, total, n;
    rst_n <= 0;
    push <= 0;
    in_sample <= '0;
    in_flush <= 0;
    cfg_valid <= 0;
    cfg_index <= '0;
    cfg_data <= '0;
    sz_x = 1; sz_y = 1; sz_z = 1; sz_t = 1; sz_c = 1; mode_q = 0;
    restart_stream();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    for (int i = 0; i < 16; i++) begin
      if (i == 4) begin
        push <= 0;
        set_volume(3, 3, 1, 1, 1, 0);
      end
      send_beat(dir_rows[i].sample, dir_rows[i].flush, dir_rows[i].typed, dir_rows[i].res);
    end
    push <= 0;

    set_volume(1, 1, 1, 4095, 1, 3);
    for (int i = 0; i < 16; i++) send_beat(rand_sample(), 1'b0, 0, '0);
    push <= 0;

    set_volume(65535, 4095, 4095, 4095, 4095, 3);
    for (int i = 0; i < 8; i++) send_beat(rand_sample(), i[0], 0, '0);
    push <= 0;

    while (random_items < 1010) begin
      quiet = random_items > 860;
      x = $urandom_range(0, 5);
      y = $urandom_range(0, 3);
      z = $urandom_range(0, 3);
      t = $urandom_range(0, 3);
      c = $urandom_range(0, 2);
      m = $urandom_range(0, 3);
      set_volume(x, y, z, t, c, m);
      if ($urandom_range(0, 9) == 0)
        write_reg(3'($urandom_range(REG_UNUSED, 7)), 16'($urandom));
      plane = 32'(eff(y) * eff(z) * eff(t) * eff(c));
      total = 32'(eff(x) * plane);
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, total) : total + plane;
      for (int i = 0; i < n; i++) begin
        if (i < total) send_beat(rand_sample(), $urandom_range(0, 15) == 0, 0, '0);
        else send_beat(16'($urandom), 1, 0, '0);
        random_items++;
      end
      push <= 0;
    end

    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire
